>>> src/miller_rabin_prime_test_64_top_defines.svh
// Assertion macros for the primality test block.
`ifndef MILLER_RABIN_PRIME_TEST_64_TOP_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_64_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define MR_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MR_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> src/mrpt_pkg.sv
// Package with shared types and constants for the primality test block.
package mrpt_pkg;
    localparam int W = 64;
    localparam int IW = 6;
    typedef logic [W-1:0] t_word;
    localparam int MAX_BASES = 7;
    localparam t_word SPR_BASES [MAX_BASES] = '{
        64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504, 64'd1795265022
    };
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_mul_ctl;
endpackage

>>> src/miller_rabin_prime_test_64_top.sv
// Top level of the deterministic Miller-Rabin primality test.
// Trivial candidates (below 3 or even) skip the multiplier; otherwise each modular
// product runs in the bit-serial multiplier, about 128 products per base, for up to
// NUM_BASES bases (clamped to 1..7). One candidate is handled at a time.
// Throughput is one transaction per test; the answer sits in an output register.
// Reset (synchronous, active low) returns the sequencer to idle and drops m_tvalid.
`include "miller_rabin_prime_test_64_top_defines.svh"
module miller_rabin_prime_test_64_top
    import mrpt_pkg::*;
#(
    parameter int NUM_BASES = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // candidate[63:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // is_prime_flag[0], zeros above
);
    localparam int NB = (NUM_BASES < 1) ? 1 : ((NUM_BASES > 7) ? 7 : NUM_BASES);

    localparam logic [3:0] S_IDLE = 4'd0, S_SPLIT = 4'd1, S_BASE = 4'd2,
                           S_EBIT = 4'd3, S_MR = 4'd4, S_MP = 4'd5,
                           S_CHK = 4'd6, S_SQ = 4'd7, S_SQW = 4'd8, S_OUT = 4'd9;

    logic [3:0]  r_st;
    t_word       r_n, r_d, r_e, r_r, r_p;
    logic [IW:0] r_s, r_j;
    logic [2:0]  r_bi;
    logic        r_res;
    logic        r_ovalid;
    logic        mul_go;
    t_word       mul_x, mul_y, mul_p;
    t_mul_ctl    mul_ctl;
    t_word       v_a;

    // The multiplier is shared by every product of the exponentiation and squaring.
    mrpt_mulmod u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_go),
        .i_x(mul_x), .i_y(mul_y), .i_m(r_n), .o_ctl(mul_ctl), .o_p(mul_p)
    );

    assign v_a      = SPR_BASES[r_bi];
    assign s_tready = (r_st == S_IDLE) && !r_ovalid;
    assign m_tvalid = r_ovalid;
    assign m_tdata  = {7'd0, r_res};

    always_comb begin
        mul_go = 1'b0;
        mul_x  = r_r;
        mul_y  = r_p;
        case (r_st)
            S_EBIT: begin
                if (r_e != '0) begin
                    mul_go = 1'b1;
                    if (!r_e[0]) begin
                        mul_x = r_p;
                    end
                end
            end
            S_MR: begin
                // After the result update, square the running power.
                if (mul_ctl.done) begin
                    mul_go = 1'b1;
                    mul_x  = r_p;
                end
            end
            S_SQ: begin
                mul_go = 1'b1;
                mul_y  = r_r;
            end
            default: mul_go = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_tready) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        r_n <= s_tdata;
                        r_d <= s_tdata - 64'd1;
                        r_s <= '0;
                        r_bi <= '0;
                        if (s_tdata == 64'd2) begin
                            r_res <= 1'b1; r_st <= S_OUT;
                        end else if (s_tdata < 64'd2 || !s_tdata[0]) begin
                            r_res <= 1'b0; r_st <= S_OUT;
                        end else begin
                            r_st <= S_SPLIT;
                        end
                    end
                end
                S_SPLIT: begin
                    // Strip one trailing zero of n-1 per cycle.
                    if (!r_d[0]) begin
                        r_d <= {1'b0, r_d[W-1:1]};
                        r_s <= r_s + 1'b1;
                    end else begin
                        r_st <= S_BASE;
                    end
                end
                S_BASE: begin
                    if (32'(r_bi) >= NB) begin
                        r_res <= 1'b1; r_st <= S_OUT;
                    end else if (v_a > r_n) begin
                        r_res <= 1'b1; r_st <= S_OUT;
                    end else begin
                        r_r  <= 64'd1;
                        r_p  <= (v_a == r_n) ? '0 : v_a;
                        r_e  <= r_d;
                        r_st <= S_EBIT;
                    end
                end
                S_EBIT: begin
                    if (r_e == '0) begin
                        r_j  <= (IW+1)'(1);
                        r_st <= S_CHK;
                    end else begin
                        r_st <= r_e[0] ? S_MR : S_MP;
                    end
                end
                S_MR: begin
                    if (mul_ctl.done) begin
                        r_r  <= mul_p;
                        r_st <= S_MP;
                    end
                end
                S_MP: begin
                    if (mul_ctl.done) begin
                        r_p  <= mul_p;
                        r_e  <= {1'b0, r_e[W-1:1]};
                        r_st <= S_EBIT;
                    end
                end
                S_CHK: begin
                    if (r_r == 64'd1 || r_r == r_n - 64'd1) begin
                        r_bi <= r_bi + 1'b1; r_st <= S_BASE;
                    end else if (r_j >= r_s) begin
                        r_res <= 1'b0; r_st <= S_OUT;
                    end else begin
                        r_st <= S_SQ;
                    end
                end
                S_SQ: r_st <= S_SQW;
                S_SQW: begin
                    if (mul_ctl.done) begin
                        r_r <= mul_p;
                        r_j <= r_j + 1'b1;
                        if (mul_p == 64'd1) begin
                            r_res <= 1'b0; r_st <= S_OUT;
                        end else if (mul_p == r_n - 64'd1) begin
                            r_bi <= r_bi + 1'b1; r_st <= S_BASE;
                        end else if (r_j + 1'b1 >= r_s) begin
                            r_res <= 1'b0; r_st <= S_OUT;
                        end else begin
                            r_st <= S_SQ;
                        end
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_st     <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `MR_ASSERT_IMP(a_out_idle, i_clk, i_rst_n, m_tvalid, r_st == S_IDLE || r_st == S_OUT)
    `MR_ASSERT_NXT(a_acc_busy, i_clk, i_rst_n, s_tvalid && s_tready, r_st != S_IDLE)
    `MR_ASSERT_IMP(a_mul_quiet, i_clk, i_rst_n, mul_go, !mul_ctl.busy || r_st == S_MR)
endmodule

>>> src/mrpt_mulmod.sv
// Bit-serial modular multiplier: one bit of the multiplier per cycle.
module mrpt_mulmod
    import mrpt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_word    i_x,
    input  t_word    i_y,
    input  t_word    i_m,
    output t_mul_ctl o_ctl,
    output t_word    o_p
);
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [IW-1:0] r_cnt, n_cnt;
    t_word         r_acc, n_acc;
    t_word         r_y, n_y;
    t_word         r_x, r_m;
    logic [W:0]    v_dbl, v_add;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_y    = r_y;
        v_dbl  = {1'b0, r_acc} + {1'b0, r_acc};
        if (v_dbl >= {1'b0, r_m}) v_dbl = v_dbl - {1'b0, r_m};
        v_add  = v_dbl + {1'b0, r_x};
        if (v_add >= {1'b0, r_m}) v_add = v_add - {1'b0, r_m};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = '0;
            n_y    = i_y;
        end else if (r_busy) begin
            n_acc = r_y[W-1] ? v_add[W-1:0] : v_dbl[W-1:0];
            n_y   = {r_y[W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == IW'(W-1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_y   <= n_y;
        if (i_start) begin
            r_x <= i_x;
            r_m <= i_m;
        end
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
    assign o_p   = r_acc;
endmodule
